@@ rtl/hce_pkg.sv @@
// Package for the Huffman codec engine: beat types, node store entry,
// command and status codes, controller states. No dependencies.
`default_nettype none
package hce_pkg;

   localparam int NODE_IDX_W = 9;
   localparam int CODE_W     = 256;
   localparam int MAX_CHUNKS = 8;

   localparam logic [2:0] CMD_CLEAR  = 3'd0;
   localparam logic [2:0] CMD_COUNT  = 3'd1;
   localparam logic [2:0] CMD_BUILD  = 3'd2;
   localparam logic [2:0] CMD_ENCODE = 3'd3;
   localparam logic [2:0] CMD_DECODE = 3'd4;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_PHASE    = 2'd2;
   localparam logic [1:0] ST_FEW      = 2'd3;

   typedef struct packed {
      logic [2:0] cmd;
      logic [7:0] symbol;
      logic       code_bit;
   } hce_req_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  decoded_symbol;
      logic        symbol_valid;
      logic [31:0] code_chunk;
      logic [5:0]  chunk_len;
      logic        last;
      logic [8:0]  distinct_count;
   } hce_rsp_type;

   typedef struct packed {
      logic [31:0]           weight;
      logic [NODE_IDX_W-1:0] parent;
      logic [NODE_IDX_W-1:0] left;
      logic [NODE_IDX_W-1:0] right;
      logic [7:0]            sym;
   } hce_node_type;

   typedef enum logic [4:0] {
      S_SWEEP, S_IDLE, S_CNT_SYM, S_CNT_ISS, S_CNT_WR,
      S_BLD_SCAN, S_BLD_TAIL, S_BLD_WA, S_BLD_WB, S_BLD_WI,
      S_ENC_SYM, S_ENC_LEAF, S_ENC_ISS, S_ENC_UP, S_ENC_OUT,
      S_DEC_RD1, S_DEC_RD2, S_RESP
   } hce_state_type;

endpackage
`default_nettype wire

@@ rtl/huffman_codec_engine.sv @@
// Count bumps the symbol's leaf weight; decode takes one code bit per item;
// encode walks leaf to root and sends chunk beats; build merges the lightest two.
// One item at a time; a finished beat in the output register does not block acceptance.
// Reset and clear sweep all max(2*MAX_SYMBOLS,256) node and symbol memory addresses,
// no item accepted meanwhile. Clear answers one beat after its sweep.
`default_nettype none
module huffman_codec_engine
   import hce_pkg::*;
#(
   parameter int MAX_SYMBOLS = 256,
   parameter int WEIGHT_BITS = 32,
   parameter int CHUNK_BITS  = 32
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output      logic        req_stall,
   input  wire hce_req_type req_data,
   output      logic        rsp_valid,
   input  wire logic        rsp_stall,
   output      hce_rsp_type rsp_data
);

   localparam int NODE_DEPTH = 2 * MAX_SYMBOLS;
   localparam int NAW        = $clog2(NODE_DEPTH);
   localparam int SYM_DEPTH  = 256;
   localparam int SWEEP_N    = (NODE_DEPTH > SYM_DEPTH) ? NODE_DEPTH : SYM_DEPTH;
   localparam int SW_W       = $clog2(SWEEP_N);
   localparam logic [31:0] WMAX = 32'((33'd1 << WEIGHT_BITS) - 33'd1);
   localparam logic [NODE_IDX_W-1:0] MAXS = NODE_IDX_W'(MAX_SYMBOLS);

   hce_state_type state_ff, state_in;
   hce_req_type   req_ff, req_in;
   hce_rsp_type   pend_ff, pend_in, rsp_ff, rsp_in;
   logic          rsp_valid_ff, rsp_valid_in;

   logic [NODE_IDX_W-1:0] leaf_total_ff, leaf_total_in;
   logic                  ready_ff, ready_in;
   logic [NODE_IDX_W-1:0] cursor_ff, cursor_in;
   logic                  clr_ff, clr_in;
   logic [SW_W-1:0]       sweep_ff, sweep_in;
   logic [NODE_IDX_W-1:0] cur_ff, cur_in;
   logic [NODE_IDX_W-1:0] j_ff, j_in;
   logic [NODE_IDX_W-1:0] jd_ff, jd_in;
   logic                  dv_ff, dv_in;
   logic [NODE_IDX_W-1:0] a_ff, a_in, b_ff, b_in, f_ff, f_in;
   hce_node_type          ea_ff, ea_in, eb_ff, eb_in;
   logic [CODE_W-1:0]     code_ff, code_in;
   logic [8:0]            len_ff, len_in;
   logic [2:0]            k_ff, k_in;

   logic                  n_we, s_we;
   logic [NAW-1:0]        n_waddr, n_raddr;
   hce_node_type          n_wdata, n_rdata;
   logic [7:0]            s_waddr, s_raddr;
   logic [NODE_IDX_W-1:0] s_wdata, s_rdata;

   logic                  accept, out_free, sweep_end, leaf_hit;
   logic [NODE_IDX_W-1:0] root, dec_start, child, n_raddr_idx;
   logic [32:0]           sum;
   logic [31:0]           chunk;
   logic [8:0]            n_bits;
   logic                  chunk_last;

   hce_ram #(.WIDTH($bits(hce_node_type)), .DEPTH(NODE_DEPTH)) u_node_ram (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_waddr),
      .wr_data (n_wdata),
      .rd_addr (n_raddr),
      .rd_data (n_rdata)
   );

   hce_ram #(.WIDTH(NODE_IDX_W), .DEPTH(SYM_DEPTH)) u_sym_ram (
      .clock   (clock),
      .wr_en   (s_we),
      .wr_addr (s_waddr),
      .wr_data (s_wdata),
      .rd_addr (s_raddr),
      .rd_data (s_rdata)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign sweep_end = (sweep_ff == SW_W'(SWEEP_N - 1));
   assign root      = (leaf_total_ff << 1) - NODE_IDX_W'(1);
   assign dec_start = (cursor_ff == '0) ? root : cursor_ff;
   assign child     = req_ff.code_bit ? n_rdata.right : n_rdata.left;
   assign leaf_hit  = (n_rdata.left == '0) && (n_rdata.right == '0);
   assign sum       = {1'b0, ea_ff.weight} + {1'b0, eb_ff.weight};
   assign n_bits    = (len_ff > 9'(CHUNK_BITS)) ? 9'(CHUNK_BITS) : len_ff;
   assign chunk_last = (len_ff <= 9'(CHUNK_BITS)) || (k_ff == 3'(MAX_CHUNKS - 1));
   assign chunk     = 32'(code_ff[CODE_W-1 -: CHUNK_BITS]) << (32 - CHUNK_BITS);
   assign n_raddr   = n_raddr_idx[NAW-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_SWEEP: begin
            if (sweep_end) state_in = clr_ff ? S_RESP : S_IDLE;
         end
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.cmd)
                  CMD_CLEAR:  state_in = S_SWEEP;
                  CMD_COUNT:  state_in = ready_ff ? S_RESP : S_CNT_SYM;
                  CMD_BUILD:  state_in = (ready_ff || leaf_total_ff < NODE_IDX_W'(2)) ?
                                         S_RESP : S_BLD_SCAN;
                  CMD_ENCODE: state_in = ready_ff ? S_ENC_SYM : S_RESP;
                  CMD_DECODE: state_in = ready_ff ? S_DEC_RD1 : S_RESP;
                  default:    state_in = S_IDLE;
               endcase
            end
         end
         S_CNT_SYM:  state_in = (s_rdata == '0 && leaf_total_ff >= MAXS) ? S_RESP : S_CNT_ISS;
         S_CNT_ISS:  state_in = S_CNT_WR;
         S_CNT_WR:   state_in = S_RESP;
         S_BLD_SCAN: state_in = (j_ff == cur_ff - NODE_IDX_W'(1)) ? S_BLD_TAIL : S_BLD_SCAN;
         S_BLD_TAIL: state_in = S_BLD_WA;
         S_BLD_WA:   state_in = S_BLD_WB;
         S_BLD_WB:   state_in = S_BLD_WI;
         S_BLD_WI:   state_in = (cur_ff == root) ? S_RESP : S_BLD_SCAN;
         S_ENC_SYM:  state_in = (s_rdata == '0) ? S_RESP : S_ENC_LEAF;
         S_ENC_LEAF: state_in = S_ENC_ISS;
         S_ENC_ISS:  state_in = S_ENC_UP;
         S_ENC_UP:   state_in = (n_rdata.parent == '0) ? S_ENC_OUT : S_ENC_ISS;
         S_ENC_OUT:  state_in = (out_free && chunk_last) ? S_IDLE : S_ENC_OUT;
         S_DEC_RD1:  state_in = S_DEC_RD2;
         S_DEC_RD2:  state_in = S_RESP;
         S_RESP:     state_in = out_free ? S_IDLE : S_RESP;
         default:    state_in = S_IDLE;
      endcase
   end

   // datapath and memory controls
   always_comb begin
      req_in        = req_ff;
      pend_in       = pend_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      leaf_total_in = leaf_total_ff;
      ready_in      = ready_ff;
      cursor_in     = cursor_ff;
      clr_in        = clr_ff;
      sweep_in      = sweep_ff;
      cur_in        = cur_ff;
      j_in          = j_ff;
      jd_in         = j_ff;
      dv_in         = (state_ff == S_BLD_SCAN);
      a_in          = a_ff;
      b_in          = b_ff;
      ea_in         = ea_ff;
      eb_in         = eb_ff;
      f_in          = f_ff;
      code_in       = code_ff;
      len_in        = len_ff;
      k_in          = k_ff;
      n_we          = 1'b0;
      n_waddr       = cur_ff[NAW-1:0];
      n_wdata       = n_rdata;
      n_raddr_idx   = cur_ff;
      s_we          = 1'b0;
      s_waddr       = req_ff.symbol;
      s_wdata       = '0;
      s_raddr       = req_data.symbol;

      // running pick of the two lightest parentless nodes
      if (dv_ff && n_rdata.parent == '0) begin
         if (a_ff == '0 || n_rdata.weight < ea_ff.weight) begin
            b_in  = a_ff;
            eb_in = ea_ff;
            a_in  = jd_ff;
            ea_in = n_rdata;
         end else if (b_ff == '0 || n_rdata.weight < eb_ff.weight) begin
            b_in  = jd_ff;
            eb_in = n_rdata;
         end
      end

      unique case (state_ff)
         S_SWEEP: begin
            n_we     = (int'(sweep_ff) < NODE_DEPTH);
            n_waddr  = sweep_ff[NAW-1:0];
            n_wdata  = '0;
            s_we     = (int'(sweep_ff) < SYM_DEPTH);
            s_waddr  = sweep_ff[7:0];
            sweep_in = sweep_ff + SW_W'(1);
            if (sweep_end) begin
               leaf_total_in = '0;
               ready_in      = 1'b0;
               cursor_in     = '0;
               pend_in       = '0;
            end
         end
         S_IDLE: begin
            n_raddr_idx = dec_start;
            if (accept) begin
               req_in  = req_data;
               pend_in = '0;
               unique case (req_data.cmd)
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     clr_in   = 1'b1;
                  end
                  CMD_COUNT: begin
                     if (ready_ff) pend_in.status = ST_PHASE;
                  end
                  CMD_BUILD: begin
                     pend_in.distinct_count = 9'(leaf_total_ff);
                     if (ready_ff) begin
                        pend_in.status = ST_PHASE;
                     end else if (leaf_total_ff < NODE_IDX_W'(2)) begin
                        pend_in.status = ST_FEW;
                     end else begin
                        cur_in = leaf_total_ff + NODE_IDX_W'(1);
                        j_in   = NODE_IDX_W'(1);
                        a_in   = '0;
                        b_in   = '0;
                     end
                  end
                  CMD_ENCODE, CMD_DECODE: begin
                     if (!ready_ff) pend_in.status = ST_PHASE;
                  end
                  default: ;
               endcase
            end
         end
         S_CNT_SYM: begin
            cur_in = s_rdata;
            if (s_rdata == '0) begin
               if (leaf_total_ff >= MAXS) begin
                  pend_in.status = ST_NOT_FOUND;
               end else begin
                  leaf_total_in = leaf_total_ff + NODE_IDX_W'(1);
                  cur_in        = leaf_total_ff + NODE_IDX_W'(1);
                  s_we          = 1'b1;
                  s_wdata       = leaf_total_ff + NODE_IDX_W'(1);
               end
            end
         end
         S_CNT_ISS: ;
         S_CNT_WR: begin
            n_we    = 1'b1;
            n_wdata = n_rdata;
            n_wdata.sym = req_ff.symbol;
            if (n_rdata.weight < WMAX) n_wdata.weight = n_rdata.weight + 32'd1;
         end
         S_BLD_SCAN: begin
            n_raddr_idx = j_ff;
            j_in        = j_ff + NODE_IDX_W'(1);
         end
         S_BLD_TAIL: ;
         S_BLD_WA: begin
            n_we    = 1'b1;
            n_waddr = a_ff[NAW-1:0];
            n_wdata = ea_ff;
            n_wdata.parent = cur_ff;
         end
         S_BLD_WB: begin
            n_we    = 1'b1;
            n_waddr = b_ff[NAW-1:0];
            n_wdata = eb_ff;
            n_wdata.parent = cur_ff;
         end
         S_BLD_WI: begin
            n_we    = 1'b1;
            n_wdata = '0;
            n_wdata.weight = (sum > {1'b0, WMAX}) ? WMAX : sum[31:0];
            n_wdata.left   = b_ff;
            n_wdata.right  = a_ff;
            if (cur_ff == root) begin
               ready_in  = 1'b1;
               cursor_in = root;
            end else begin
               cur_in = cur_ff + NODE_IDX_W'(1);
               j_in   = NODE_IDX_W'(1);
               a_in   = '0;
               b_in   = '0;
            end
         end
         S_ENC_SYM: begin
            cur_in      = s_rdata;
            n_raddr_idx = s_rdata;
            if (s_rdata == '0) pend_in.status = ST_NOT_FOUND;
         end
         S_ENC_LEAF: begin
            f_in    = n_rdata.parent;
            code_in = '0;
            len_in  = '0;
         end
         S_ENC_ISS: begin
            n_raddr_idx = f_ff;
         end
         S_ENC_UP: begin
            code_in = {(n_rdata.right == cur_ff), code_ff[CODE_W-1:1]};
            len_in  = len_ff + 9'd1;
            cur_in  = f_ff;
            f_in    = n_rdata.parent;
            k_in    = '0;
         end
         S_ENC_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               rsp_in.status     = ST_OK;
               rsp_in.code_chunk = chunk;
               rsp_in.chunk_len  = 6'(n_bits);
               rsp_in.last       = chunk_last;
               code_in = code_ff << CHUNK_BITS;
               len_in  = len_ff - n_bits;
               k_in    = k_ff + 3'd1;
            end
         end
         S_DEC_RD1: begin
            n_raddr_idx = child;
            f_in        = child;
         end
         S_DEC_RD2: begin
            if (leaf_hit) begin
               pend_in.decoded_symbol = n_rdata.sym;
               pend_in.symbol_valid   = 1'b1;
               cursor_in              = root;
            end else begin
               cursor_in = f_ff;
            end
         end
         S_RESP: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
               clr_in       = 1'b0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_SWEEP;
         rsp_valid_ff  <= 1'b0;
         leaf_total_ff <= '0;
         ready_ff      <= 1'b0;
         cursor_ff     <= '0;
         clr_ff        <= 1'b0;
         sweep_ff      <= '0;
         dv_ff         <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         leaf_total_ff <= leaf_total_in;
         ready_ff      <= ready_in;
         cursor_ff     <= cursor_in;
         clr_ff        <= clr_in;
         sweep_ff      <= sweep_in;
         dv_ff         <= dv_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff  <= req_in;
      pend_ff <= pend_in;
      rsp_ff  <= rsp_in;
      cur_ff  <= cur_in;
      j_ff    <= j_in;
      jd_ff   <= jd_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      ea_ff   <= ea_in;
      eb_ff   <= eb_in;
      f_ff    <= f_in;
      code_ff <= code_in;
      len_ff  <= len_in;
      k_ff    <= k_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ rtl/hce_ram.sv @@
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`default_nettype none
module hce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/hce_checker.sv @@
// Port-level checks for huffman_codec_engine, bound to the top level.
// Depends on hce_pkg.
`default_nettype none
module hce_assertions
   import hce_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire hce_rsp_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled beat changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("beat right after reset");

   a_sym_no_chunk: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.symbol_valid |-> rsp_data.chunk_len == 6'd0 && !rsp_data.last)
      else $error("decode beat carries code bits");

   a_chunk_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.chunk_len != 6'd0 |->
         rsp_data.status == ST_OK && rsp_data.chunk_len <= 6'd32)
      else $error("bad chunk beat");

endmodule

bind huffman_codec_engine hce_assertions u_hce_assertions (.*);
`default_nettype wire
